// File: rtl/core/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types, widths and codes for the moving-average crossover block.
// ----------------------------------------------------------------------------
package mac_pkg;

  localparam int HIST_DEPTH = 256;
  localparam int PRICE_BITS = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int LEN_W      = 8;
  localparam int SUM_W      = PRICE_BITS + LEN_W;
  localparam int PROD_W     = SUM_W + LEN_W;
  localparam int BARS_W     = 9;
  localparam int PADDR_W    = 4;
  localparam int QTY_W      = 8;

  localparam logic [BARS_W-1:0] BARS_MAX = '1;

  localparam logic [1:0] REG_SHORT_LEN  = 2'd0;
  localparam logic [1:0] REG_LONG_LEN   = 2'd1;
  localparam logic [1:0] REG_STOCK_MODE = 2'd2;

  localparam logic [LEN_W-1:0] SHORT_LEN_RST = LEN_W'(5);
  localparam logic [LEN_W-1:0] LONG_LEN_RST  = LEN_W'(20);

  localparam logic [1:0] POS_FLAT  = 2'd0;
  localparam logic [1:0] POS_LONG  = 2'd1;
  localparam logic [1:0] POS_SHORT = 2'd2;

  localparam logic [QTY_W-1:0] QTY_FUTURE = QTY_W'(2 * 1);
  localparam logic [QTY_W-1:0] QTY_STOCK  = QTY_W'(2 * 100);

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ENTER_LONG  = 3'd1,
    ACT_ENTER_SHORT = 3'd2,
    ACT_EXIT_LONG   = 3'd3,
    ACT_EXIT_SHORT  = 3'd4
  } action_t;

  typedef struct packed {
    logic [31:0] close_price;
    logic [1:0]  position_sign;
  } price_word_t;

  typedef struct packed {
    action_t          action;
    logic [QTY_W-1:0] quantity;
    logic             warmed_up;
  } signal_word_t;

  // bar after history read issue
  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [1:0]            pos;
    logic                  warm;
    logic                  sub_s;
    logic                  sub_l;
  } s1_t;

  // bar with window sums before and after it
  typedef struct packed {
    logic [SUM_W-1:0] pre_s;
    logic [SUM_W-1:0] pre_l;
    logic [SUM_W-1:0] now_s;
    logic [SUM_W-1:0] now_l;
    logic [1:0]       pos;
    logic             warm;
  } s2_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = (v == '0) ? LEN_W'(1) : v;
    if (int'(n) > HIST_DEPTH - 1) n = LEN_W'(HIST_DEPTH - 1);
    return n;
  endfunction

endpackage

// File: rtl/core/mac_history.sv
// ----------------------------------------------------------------------------
// mac_history
// Price history RAM: one write and two registered reads per enabled cycle.
// ----------------------------------------------------------------------------
module mac_history (
  input  logic                           clk,
  input  logic                           en,
  input  logic [mac_pkg::HIST_AW-1:0]    wr_addr,
  input  logic [mac_pkg::PRICE_BITS-1:0] wr_data,
  input  logic [mac_pkg::HIST_AW-1:0]    rd_addr_a,
  input  logic [mac_pkg::HIST_AW-1:0]    rd_addr_b,
  output logic [mac_pkg::PRICE_BITS-1:0] rd_data_a,
  output logic [mac_pkg::PRICE_BITS-1:0] rd_data_b
);
  import mac_pkg::*;

  logic [PRICE_BITS-1:0] mem [HIST_DEPTH];

  // read addresses are always behind the write address, never equal to it
  always_ff @(posedge clk) begin
    if (en) begin
      mem[wr_addr] <= wr_data;
      rd_data_a    <= mem[rd_addr_a];
      rd_data_b    <= mem[rd_addr_b];
    end
  end

endmodule

// File: rtl/core/mac_window.sv
// ----------------------------------------------------------------------------
// mac_window
// Running sums for the short and long windows, updated once per bar.
// ----------------------------------------------------------------------------
module mac_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           load,
  input  mac_pkg::s1_t                   s1,
  input  logic [mac_pkg::PRICE_BITS-1:0] old_s,
  input  logic [mac_pkg::PRICE_BITS-1:0] old_l,
  output mac_pkg::s2_t                   s2
);
  import mac_pkg::*;

  logic [SUM_W-1:0] sum_s;
  logic [SUM_W-1:0] sum_l;
  logic [SUM_W-1:0] sum_s_next;
  logic [SUM_W-1:0] sum_l_next;

  always_comb begin
    sum_s_next = sum_s + SUM_W'(s1.price) - (s1.sub_s ? SUM_W'(old_s) : '0);
    sum_l_next = sum_l + SUM_W'(s1.price) - (s1.sub_l ? SUM_W'(old_l) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sum_s <= '0;
      sum_l <= '0;
    end else if (load) begin
      sum_s <= sum_s_next;
      sum_l <= sum_l_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2.pre_s <= sum_s;
      s2.pre_l <= sum_l;
      s2.now_s <= sum_s_next;
      s2.now_l <= sum_l_next;
      s2.pos   <= s1.pos;
      s2.warm  <= s1.warm;
    end
  end

endmodule

// File: rtl/core/mac_decide.sv
// ----------------------------------------------------------------------------
// mac_decide
// Cross-multiplies window sums by lengths, detects crosses, forms the order.
// ----------------------------------------------------------------------------
module mac_decide (
  input  logic                      clk,
  input  logic                      load_prod,
  input  logic                      load_out,
  input  mac_pkg::s2_t              s2,
  input  logic [mac_pkg::LEN_W-1:0] short_len,
  input  logic [mac_pkg::LEN_W-1:0] long_len,
  input  logic                      stock_mode,
  output mac_pkg::signal_word_t     result
);
  import mac_pkg::*;

  logic [PROD_W-1:0] pre_a;
  logic [PROD_W-1:0] pre_b;
  logic [PROD_W-1:0] now_a;
  logic [PROD_W-1:0] now_b;
  logic [1:0]        pos;
  logic              warm;

  logic              golden;
  logic              death;
  action_t           act;
  signal_word_t      result_next;

  // short average vs long average: sum_s * long_len against sum_l * short_len
  always_ff @(posedge clk) begin
    if (load_prod) begin
      pre_a <= PROD_W'(s2.pre_s) * PROD_W'(long_len);
      pre_b <= PROD_W'(s2.pre_l) * PROD_W'(short_len);
      now_a <= PROD_W'(s2.now_s) * PROD_W'(long_len);
      now_b <= PROD_W'(s2.now_l) * PROD_W'(short_len);
      pos   <= s2.pos;
      warm  <= s2.warm;
    end
  end

  always_comb begin
    golden = (pre_a < pre_b) && (now_a > now_b);
    death  = (pre_a > pre_b) && (now_a < now_b);
    act    = ACT_NONE;
    if (warm) begin
      case (pos)
        POS_FLAT: begin
          if (golden)                   act = ACT_ENTER_LONG;
          else if (death && !stock_mode) act = ACT_ENTER_SHORT;
        end
        POS_LONG: begin
          if (death) act = ACT_EXIT_LONG;
        end
        POS_SHORT: begin
          if (golden && !stock_mode) act = ACT_EXIT_SHORT;
        end
        default: act = ACT_NONE;
      endcase
    end
    result_next.action    = act;
    result_next.quantity  = (act == ACT_NONE) ? '0 : (stock_mode ? QTY_STOCK : QTY_FUTURE);
    result_next.warmed_up = warm;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/core/ma_crossover_signal.sv
// ----------------------------------------------------------------------------
// ma_crossover_signal
// Dual moving-average crossover: price history RAM, running window sums and
// cross detection by cross-multiplication, with an APB-style register port.
// ----------------------------------------------------------------------------
// Flow: a taken price word is registered into the first stage with its two
// history reads, then the window sums, then the cross products, then the signal word that drives signal_valid.
// Throughput: one word per cycle while signal_stall is low; the history RAM does two reads and one
// write per bar in the same cycle, and the sums update once per bar.
// Reset: pointers, bar count, sums and registers return to their defaults
// (short 5, long 20, futures); history RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ma_crossover_signal (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mac_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         price_valid,
  output logic                         price_stall,
  input  mac_pkg::price_word_t         price_word,
  output logic                         signal_valid,
  input  logic                         signal_stall,
  output mac_pkg::signal_word_t        signal_word
);
  import mac_pkg::*;

  logic [LEN_W-1:0]      short_len;
  logic [LEN_W-1:0]      long_len;
  logic                  stock_mode;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;
  logic                  restart;

  logic [HIST_AW-1:0]    wp;
  logic [BARS_W-1:0]     bars_seen;
  logic [LEN_W-1:0]      max_len;

  logic                  s1_v;
  logic                  s2_v;
  logic                  s3_v;
  logic                  adv1;
  logic                  adv2;
  logic                  adv3;
  logic                  s1_free;
  logic                  s2_free;
  logic                  s3_free;
  logic                  out_free;
  logic                  accept;

  s1_t                   s1;
  s1_t                   s1_next;
  s2_t                   s2;
  logic [PRICE_BITS-1:0] old_s;
  logic [PRICE_BITS-1:0] old_l;
  logic [HIST_AW-1:0]    addr_s;
  logic [HIST_AW-1:0]    addr_l;

  // ---- register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign restart = cfg_wr && (cfg_idx == REG_SHORT_LEN || cfg_idx == REG_LONG_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_len  <= SHORT_LEN_RST;
      long_len   <= LONG_LEN_RST;
      stock_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHORT_LEN:  short_len  <= clamp_len(pwdata[LEN_W-1:0]);
        REG_LONG_LEN:   long_len   <= clamp_len(pwdata[LEN_W-1:0]);
        REG_STOCK_MODE: stock_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHORT_LEN:  prdata = 32'(short_len);
      REG_LONG_LEN:   prdata = 32'(long_len);
      REG_STOCK_MODE: prdata = 32'(stock_mode);
      default:        prdata = '0;
    endcase
  end

  // ---- pipeline flow
  assign out_free    = !signal_valid || !signal_stall;
  assign adv3        = s3_v && out_free;
  assign s3_free     = !s3_v || adv3;
  assign adv2        = s2_v && s3_free;
  assign s2_free     = !s2_v || adv2;
  assign adv1        = s1_v && s2_free;
  assign s1_free     = !s1_v || adv1;
  assign price_stall = !s1_free;
  assign accept      = price_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      signal_valid <= 1'b0;
    end else begin
      s1_v         <= accept || (s1_v && !adv1);
      s2_v         <= adv1 || (s2_v && !adv2);
      s3_v         <= adv2 || (s3_v && !adv3);
      signal_valid <= adv3 || (signal_valid && signal_stall);
    end
  end

  // ---- history addressing and bar count
  assign max_len = (short_len > long_len) ? short_len : long_len;

  always_comb begin
    addr_s = ((HIST_AW+1)'(wp) >= (HIST_AW+1)'(short_len))
           ? HIST_AW'((HIST_AW+1)'(wp) - (HIST_AW+1)'(short_len))
           : HIST_AW'((HIST_AW+1)'(wp) + (HIST_AW+1)'(HIST_DEPTH)
                      - (HIST_AW+1)'(short_len));
    addr_l = ((HIST_AW+1)'(wp) >= (HIST_AW+1)'(long_len))
           ? HIST_AW'((HIST_AW+1)'(wp) - (HIST_AW+1)'(long_len))
           : HIST_AW'((HIST_AW+1)'(wp) + (HIST_AW+1)'(HIST_DEPTH)
                      - (HIST_AW+1)'(long_len));
    s1_next.price = PRICE_BITS'(price_word.close_price);
    s1_next.pos   = price_word.position_sign;
    s1_next.warm  = bars_seen >= BARS_W'(max_len);
    s1_next.sub_s = bars_seen >= BARS_W'(short_len);
    s1_next.sub_l = bars_seen >= BARS_W'(long_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (accept) begin
      wp <= (int'(wp) == HIST_DEPTH - 1) ? '0 : wp + HIST_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      bars_seen <= '0;
    end else if (accept && bars_seen != BARS_MAX) begin
      bars_seen <= bars_seen + BARS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  mac_history u_history (
    .clk       (clk),
    .en        (accept),
    .wr_addr   (wp),
    .wr_data   (s1_next.price),
    .rd_addr_a (addr_s),
    .rd_addr_b (addr_l),
    .rd_data_a (old_s),
    .rd_data_b (old_l)
  );

  mac_window u_window (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .load    (adv1),
    .s1      (s1),
    .old_s   (old_s),
    .old_l   (old_l),
    .s2      (s2)
  );

  mac_decide u_decide (
    .clk        (clk),
    .load_prod  (adv2),
    .load_out   (adv3),
    .s2         (s2),
    .short_len  (short_len),
    .long_len   (long_len),
    .stock_mode (stock_mode),
    .result     (signal_word)
  );

  // ---- checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    price_stall |-> s1_v)
    else $error("price stalled with an empty first stage");

  a_cold_no_action: assert property (@(posedge clk) disable iff (rst)
    signal_valid && !signal_word.warmed_up |-> signal_word.action == ACT_NONE)
    else $error("action before warm-up");

  a_qty_matches_action: assert property (@(posedge clk) disable iff (rst)
    signal_valid |-> ((signal_word.action == ACT_NONE) == (signal_word.quantity == '0)))
    else $error("quantity does not match action");

  a_stock_no_short: assert property (@(posedge clk) disable iff (rst)
    signal_valid && stock_mode |->
      signal_word.action != ACT_ENTER_SHORT && signal_word.action != ACT_EXIT_SHORT)
    else $error("short-side action in stock mode");

endmodule

// File: verif/ma_crossover_checker.sv
// ----------------------------------------------------------------------------
// ma_crossover_checker
// Watches the register, price and signal channels of the crossover block.
// Keeps its own price history, window sums and lengths, predicts one signal
// word per accepted price word and compares it with the oldest outstanding
// prediction. Register reads are checked against the lengths and mode held.
// ----------------------------------------------------------------------------
module ma_crossover_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mac_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  input  logic                        price_valid,
  input  logic                        price_stall,
  input  mac_pkg::price_word_t        price_word,
  input  logic                        signal_valid,
  input  logic                        signal_stall,
  input  mac_pkg::signal_word_t       signal_word,
  output int                          fail_count,
  output int                          pending
);
  import mac_pkg::*;

  logic [PRICE_BITS-1:0] hist [HIST_DEPTH];
  logic [SUM_W-1:0]      sum_short;
  logic [SUM_W-1:0]      sum_long;
  logic [HIST_AW-1:0]    wr_ptr;
  logic [BARS_W-1:0]     bar_count;
  logic [LEN_W-1:0]      len_short;
  logic [LEN_W-1:0]      len_long;
  logic                  stock;
  signal_word_t          expected_signals [$];

  // zero reads as one, anything past the history depth is cut back
  function automatic logic [LEN_W-1:0] fit_len(input logic [31:0] v);
    int n;
    n = int'(v[LEN_W-1:0]);
    if (n == 0) n = 1;
    if (n > HIST_DEPTH - 1) n = HIST_DEPTH - 1;
    return LEN_W'(n);
  endfunction

  function automatic void restart_windows();
    sum_short = '0;
    sum_long  = '0;
    bar_count = '0;
  endfunction

  // sign of a*x - b*y, no division needed
  function automatic int weigh(input logic [SUM_W-1:0] a, input logic [LEN_W-1:0] x,
                               input logic [SUM_W-1:0] b, input logic [LEN_W-1:0] y);
    logic [PROD_W-1:0] pa;
    logic [PROD_W-1:0] pb;
    pa = PROD_W'(a) * PROD_W'(x);
    pb = PROD_W'(b) * PROD_W'(y);
    if (pa < pb) return -1;
    if (pa > pb) return 1;
    return 0;
  endfunction

  function automatic signal_word_t next_signal(input price_word_t w);
    logic [PRICE_BITS-1:0] price;
    logic [LEN_W-1:0]      top_len;
    logic [SUM_W-1:0]      pre_s;
    logic [SUM_W-1:0]      pre_l;
    logic [SUM_W-1:0]      now_s;
    logic [SUM_W-1:0]      now_l;
    logic                  warm;
    logic                  golden;
    logic                  death;
    action_t               act;
    signal_word_t          r;
    price   = PRICE_BITS'(w.close_price);
    top_len = (len_short > len_long) ? len_short : len_long;
    warm    = (bar_count >= BARS_W'(top_len));
    pre_s   = sum_short;
    pre_l   = sum_long;
    now_s   = pre_s + SUM_W'(price);
    now_l   = pre_l + SUM_W'(price);
    if (bar_count >= BARS_W'(len_short))
      now_s = now_s - SUM_W'(hist[HIST_AW'(wr_ptr - len_short)]);
    if (bar_count >= BARS_W'(len_long))
      now_l = now_l - SUM_W'(hist[HIST_AW'(wr_ptr - len_long)]);
    hist[wr_ptr] = price;
    wr_ptr       = wr_ptr + HIST_AW'(1);
    sum_short    = now_s;
    sum_long     = now_l;
    if (bar_count != BARS_MAX) bar_count = bar_count + BARS_W'(1);

    golden = 1'b0;
    death  = 1'b0;
    act    = ACT_NONE;
    if (warm) begin
      golden = weigh(pre_s, len_long, pre_l, len_short) < 0 &&
               weigh(now_s, len_long, now_l, len_short) > 0;
      death  = weigh(pre_s, len_long, pre_l, len_short) > 0 &&
               weigh(now_s, len_long, now_l, len_short) < 0;
      case (w.position_sign)
        POS_FLAT: begin
          if (golden) act = ACT_ENTER_LONG;
          else if (death && !stock) act = ACT_ENTER_SHORT;
        end
        POS_LONG: begin
          if (death) act = ACT_EXIT_LONG;
        end
        POS_SHORT: begin
          if (golden && !stock) act = ACT_EXIT_SHORT;
        end
        default: act = ACT_NONE;
      endcase
    end
    r.action    = act;
    r.quantity  = (act == ACT_NONE) ? '0 : (stock ? QTY_STOCK : QTY_FUTURE);
    r.warmed_up = warm;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    signal_word_t exp;
    logic [31:0]  rd_exp;
    logic         rd_known;
    if (rst) begin
      restart_windows();
      wr_ptr    = '0;
      len_short = SHORT_LEN_RST;
      len_long  = LONG_LEN_RST;
      stock     = 1'b0;
      expected_signals.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_SHORT_LEN: begin
              len_short = fit_len(pwdata);
              restart_windows();
            end
            REG_LONG_LEN: begin
              len_long = fit_len(pwdata);
              restart_windows();
            end
            REG_STOCK_MODE: stock = pwdata[0];
            default: ;
          endcase
        end else begin
          rd_known = 1'b1;
          rd_exp   = '0;
          case (paddr[PADDR_W-1:2])
            REG_SHORT_LEN:  rd_exp = 32'(len_short);
            REG_LONG_LEN:   rd_exp = 32'(len_long);
            REG_STOCK_MODE: rd_exp = 32'(stock);
            default:        rd_known = 1'b0;
          endcase
          if (rd_known && prdata !== rd_exp) begin
            $error("prdata: expected %0d, got %0d", rd_exp, prdata);
            fail_count = fail_count + 1;
          end
        end
      end

      if (signal_valid && !signal_stall) begin
        if (pending == 0) begin
          $error("signal word %h with no bar outstanding", signal_word);
          fail_count = fail_count + 1;
        end else begin
          exp     = expected_signals.pop_front();
          pending = pending - 1;
          if (signal_word.action !== exp.action) begin
            $error("action: expected %0d, got %0d", exp.action, signal_word.action);
            fail_count = fail_count + 1;
          end
          if (signal_word.quantity !== exp.quantity) begin
            $error("quantity: expected %0d, got %0d", exp.quantity, signal_word.quantity);
            fail_count = fail_count + 1;
          end
          if (signal_word.warmed_up !== exp.warmed_up) begin
            $error("warmed_up: expected %0d, got %0d", exp.warmed_up,
                   signal_word.warmed_up);
            fail_count = fail_count + 1;
          end
        end
      end

      if (price_valid && !price_stall) begin
        expected_signals.push_back(next_signal(price_word));
        pending = pending + 1;
      end
    end
  end

endmodule

// File: verif/tb_ma_crossover_signal.sv
// ----------------------------------------------------------------------------
// tb_ma_crossover_signal
// Drives bars into the crossover block: a short directed run through every
// action, the stock-mode suppression and the warm-up edge, then trending
// random walks under several window settings. A checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ma_crossover_signal;
  import mac_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0] POS_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 3000;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                price_valid;
  logic                price_stall;
  price_word_t         price_word;
  logic                signal_valid;
  logic                signal_stall;
  signal_word_t        signal_word;
  int                  fails;
  int                  pending;
  logic                quiet_send;

  ma_crossover_signal dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .price_valid  (price_valid),
    .price_stall  (price_stall),
    .price_word   (price_word),
    .signal_valid (signal_valid),
    .signal_stall (signal_stall),
    .signal_word  (signal_word)
  );

  ma_crossover_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .price_valid  (price_valid),
    .price_stall  (price_stall),
    .price_word   (price_word),
    .signal_valid (signal_valid),
    .signal_stall (signal_stall),
    .signal_word  (signal_word),
    .fail_count   (fails),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] pick_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return POS_UNUSED;
    if (r < 8) return POS_FLAT;
    if (r < 14) return POS_LONG;
    return POS_SHORT;
  endfunction

  // entered and left at a falling edge; valid stays up for a following word
  task automatic bar(input logic [31:0] p, input logic [1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      price_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    price_valid <= 1'b1;
    price_word  <= {p, s};
    do @(posedge clk); while (price_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    price_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper data bits are junk on purpose
  task automatic configure(input logic [7:0] s, input logic [7:0] l, input logic stk);
    logic [31:0] d;
    drain();
    d = $urandom; d[LEN_W-1:0] = s;
    apb_access(1'b1, REG_SHORT_LEN, d);
    d = $urandom; d[LEN_W-1:0] = l;
    apb_access(1'b1, REG_LONG_LEN, d);
    d = $urandom; d[0] = stk;
    apb_access(1'b1, REG_STOCK_MODE, d);
    apb_access(1'b0, REG_SHORT_LEN, '0);
    apb_access(1'b0, REG_LONG_LEN, '0);
    apb_access(1'b0, REG_STOCK_MODE, '0);
  endtask

  // trending walk so the averages actually cross; some wild bars mixed in
  task automatic run_walk(input int n, input int span);
    logic [31:0] level;
    logic [31:0] p;
    int          trend;
    int          run_left;
    int          k;
    int          r;
    level    = $urandom;
    trend    = 0;
    run_left = 0;
    for (k = 0; k < n; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 2 * span + 1);
        trend    = $urandom_range(0, 1 << $urandom_range(0, 16));
        if ($urandom_range(0, 1)) trend = -trend;
      end
      run_left--;
      level = level + 32'(trend) + 32'($urandom_range(0, 64)) - 32'd32;
      r = $urandom_range(0, 99);
      if (r < 2) p = '1;
      else if (r < 4) p = '0;
      else if (r < 8) p = $urandom;
      else p = level;
      if (k % 16 == 0) quiet_send = ($urandom_range(0, 3) == 0);
      bar(p, pick_pos());
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin : stall_gen
    int   hold;
    int   mode_left;
    logic busy;
    signal_stall = 1'b0;
    hold      = 0;
    mode_left = 0;
    busy      = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        busy      = ($urandom_range(0, 3) != 0);
      end
      mode_left--;
      if (hold > 0) hold--;
      else if (busy && $urandom_range(0, 9) < 3)
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      signal_stall <= (hold > 0);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((price_valid && !price_stall) || (signal_valid && !signal_stall)) idle = 0;
      else idle++;
    end
    $display("tb_ma_crossover_signal: done, errors");
    $finish;
  end

  initial begin : stimulus
    int          k;
    logic [31:0] d;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    price_valid = 1'b0;
    price_word  = '0;
    quiet_send  = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short 0 is taken as 1; one-bar against two-bar average
    configure(8'd0, 8'd2, 1'b0);
    bar(32'd100, POS_FLAT);        // warming
    bar(32'd50, POS_FLAT);         // warming
    bar(32'd200, POS_FLAT);        // golden, enter long
    bar(32'd100, POS_LONG);        // death, exit long
    bar(32'd300, POS_SHORT);       // golden, exit short
    bar(32'd0, POS_FLAT);          // death, enter short
    bar(32'hFFFF_FFFF, POS_UNUSED); // golden, meaningless position
    bar(32'd0, POS_SHORT);         // death, short holds
    bar(32'hFFFF_FFFF, POS_LONG);  // golden, long holds

    // stock mode without restarting the windows
    drain();
    d = $urandom; d[0] = 1'b1;
    apb_access(1'b1, REG_STOCK_MODE, d);
    apb_access(1'b0, REG_STOCK_MODE, '0);
    bar(32'd0, POS_FLAT);          // death, short entry suppressed
    bar(32'hFFFF_FFFF, POS_SHORT); // golden, short exit suppressed
    bar(32'd0, POS_LONG);          // death still exits long
    bar(32'hFFFF_FFFF, POS_FLAT);  // golden, enter long
    bar(32'hFFFF_FFFF, POS_FLAT);  // averages level, no cross

    drain();
    apb_access(1'b1, REG_UNUSED, $urandom);

    // long run: bar count saturates, stock flips mid-way
    configure(8'd2, 8'd7, 1'b0);
    run_walk(280, 7);
    drain();
    d = $urandom; d[0] = 1'b1;
    apb_access(1'b1, REG_STOCK_MODE, d);
    run_walk(250, 7);

    configure(8'd255, 8'd1, 1'b0);
    run_walk(275, 255);

    for (k = 0; k < 3; k++) begin
      configure(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                1'($urandom_range(0, 1)));
      run_walk(40, 12);
    end

    drain();
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_ma_crossover_signal: done, clean");
    end else begin
      $display("tb_ma_crossover_signal: done, errors");
    end
    $finish;
  end

endmodule
